// ===== rtl/core/rme_pkg.sv =====
// Shared constants and functions for the rotation matrix to Euler angle block.
`default_nettype none
package rme_pkg;

  localparam int unsigned GuardBits = 24;
  localparam int unsigned HeadBits  = 6;
  localparam int unsigned GainShift = 30 - GuardBits;
  localparam logic [31:0] HalfTurn  = 32'h8000_0000;

  function automatic logic [31:0] atan_step(input int unsigned idx);
    logic [31:0] t;
    case (idx)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
      21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
      24: t = 32'h00000029;  25: t = 32'h00000014;  26: t = 32'h0000000A;
      27: t = 32'h00000005;  28: t = 32'h00000003;  29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  function automatic logic [63:0] gain_q30(input int unsigned steps);
    logic [63:0] p;
    logic [63:0] root;
    logic [63:0] bitv;
    p    = 64'd1 << 60;
    root = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (i < steps) begin
        p = p + (p >> (2 * i));
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv > p) begin
        bitv = bitv >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (p >= root + bitv) begin
          p    = p - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return root;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rme_yaw_cell.sv =====
// One yaw micro-rotation cell: vectors (x,y) and rotates both companion vectors alike.
`default_nettype none
module rme_yaw_cell #(
  parameter int unsigned DW  = 46,
  parameter int unsigned IDX = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [DW-1:0] x_i,
  input  wire logic signed [DW-1:0] y_i,
  input  wire logic        [31:0]   z_i,
  input  wire logic signed [DW-1:0] a0_i,
  input  wire logic signed [DW-1:0] b0_i,
  input  wire logic signed [DW-1:0] a1_i,
  input  wire logic signed [DW-1:0] b1_i,
  input  wire logic signed [DW-1:0] ky_i,
  input  wire logic                 zero_i,
  output logic                      valid_o,
  output logic signed [DW-1:0]      x_o,
  output logic signed [DW-1:0]      y_o,
  output logic        [31:0]        z_o,
  output logic signed [DW-1:0]      a0_o,
  output logic signed [DW-1:0]      b0_o,
  output logic signed [DW-1:0]      a1_o,
  output logic signed [DW-1:0]      b1_o,
  output logic signed [DW-1:0]      ky_o,
  output logic                      zero_o
);
  localparam logic [31:0] Step = rme_pkg::atan_step(IDX);

  logic                 down;
  logic signed [DW-1:0] x_d, y_d, a0_d, b0_d, a1_d, b1_d;
  logic        [31:0]   z_d;

  always_comb begin
    down = ~y_i[DW-1];
    if (down) begin
      x_d  = x_i + (y_i >>> IDX);
      y_d  = y_i - (x_i >>> IDX);
      z_d  = z_i + Step;
      a0_d = a0_i + (b0_i >>> IDX);
      b0_d = b0_i - (a0_i >>> IDX);
      a1_d = a1_i + (b1_i >>> IDX);
      b1_d = b1_i - (a1_i >>> IDX);
    end else begin
      x_d  = x_i - (y_i >>> IDX);
      y_d  = y_i + (x_i >>> IDX);
      z_d  = z_i - Step;
      a0_d = a0_i - (b0_i >>> IDX);
      b0_d = b0_i + (a0_i >>> IDX);
      a1_d = a1_i - (b1_i >>> IDX);
      b1_d = b1_i + (a1_i >>> IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    z_o    <= z_d;
    a0_o   <= a0_d;
    b0_o   <= b0_d;
    a1_o   <= a1_d;
    b1_o   <= b1_d;
    ky_o   <= ky_i;
    zero_o <= zero_i;
  end
endmodule
`default_nettype wire

// ===== rtl/core/rme_pr_cell.sv =====
// One pitch/roll micro-rotation cell: two independent vectoring rotators side by side.
`default_nettype none
module rme_pr_cell #(
  parameter int unsigned DW  = 46,
  parameter int unsigned IDX = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [DW-1:0] px_i,
  input  wire logic signed [DW-1:0] py_i,
  input  wire logic        [31:0]   pz_i,
  input  wire logic signed [DW-1:0] rx_i,
  input  wire logic signed [DW-1:0] ry_i,
  input  wire logic        [31:0]   rz_i,
  input  wire logic                 pzero_i,
  input  wire logic                 rzero_i,
  input  wire logic        [31:0]   yaw_i,
  output logic                      valid_o,
  output logic signed [DW-1:0]      px_o,
  output logic signed [DW-1:0]      py_o,
  output logic        [31:0]        pz_o,
  output logic signed [DW-1:0]      rx_o,
  output logic signed [DW-1:0]      ry_o,
  output logic        [31:0]        rz_o,
  output logic                      pzero_o,
  output logic                      rzero_o,
  output logic        [31:0]        yaw_o
);
  localparam logic [31:0] Step = rme_pkg::atan_step(IDX);

  logic signed [DW-1:0] px_d, py_d, rx_d, ry_d;
  logic        [31:0]   pz_d, rz_d;

  always_comb begin
    if (!py_i[DW-1]) begin
      px_d = px_i + (py_i >>> IDX);
      py_d = py_i - (px_i >>> IDX);
      pz_d = pz_i + Step;
    end else begin
      px_d = px_i - (py_i >>> IDX);
      py_d = py_i + (px_i >>> IDX);
      pz_d = pz_i - Step;
    end
    if (!ry_i[DW-1]) begin
      rx_d = rx_i + (ry_i >>> IDX);
      ry_d = ry_i - (rx_i >>> IDX);
      rz_d = rz_i + Step;
    end else begin
      rx_d = rx_i - (ry_i >>> IDX);
      ry_d = ry_i + (rx_i >>> IDX);
      rz_d = rz_i - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_o    <= px_d;
    py_o    <= py_d;
    pz_o    <= pz_d;
    rx_o    <= rx_d;
    ry_o    <= ry_d;
    rz_o    <= rz_d;
    pzero_o <= pzero_i;
    rzero_o <= rzero_i;
    yaw_o   <= yaw_i;
  end
endmodule
`default_nettype wire

// ===== rtl/core/rotation_matrix_to_euler.sv =====
// Top level: rotation matrix to Z-Y-X Euler angles through chains of CORDIC cells.
//
// Usage: drive the seven matrix elements (m00, m10, m20, m01, m11, m02, m12)
// and pulse start_i. busy_o stays low, so a transfer happens at every edge
// where start_i is high; a new matrix may enter in every cycle.
// Results (yaw, pitch, roll as binary angles, pi/2^(ANGLE_WIDTH-1) rad per
// unit) appear on the result ports for one cycle with done_o high, after
// one input register with the gain multiplier, one yaw setup stage,
// CORDIC_STEPS yaw cells, one pitch/roll setup stage, CORDIC_STEPS
// pitch/roll cells and one rounding stage. Throughput is one matrix per
// cycle; the chain of cells sets the latency.
// The receiver cannot stall: each result is presented exactly once.
// Reset clears the valid bits along the chain, so no result comes out of
// an item that was not transferred. The block holds no other control state.
`default_nettype none
module rotation_matrix_to_euler #(
  parameter int unsigned ELEMENT_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STEPS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m00_i,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m10_i,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m20_i,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m01_i,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m11_i,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m02_i,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m12_i,
  output logic                                 done_o,
  output logic signed [ANGLE_WIDTH-1:0]        yaw_angle_o,
  output logic signed [ANGLE_WIDTH-1:0]        pitch_angle_o,
  output logic signed [ANGLE_WIDTH-1:0]        roll_angle_o
);
  localparam int unsigned EW  = ELEMENT_WIDTH;
  localparam int unsigned S   = CORDIC_STEPS;
  localparam int unsigned DW  = EW + rme_pkg::GuardBits + rme_pkg::HeadBits;
  localparam int unsigned PW  = EW + 31;
  localparam int unsigned MW  = PW - rme_pkg::GainShift;
  localparam int unsigned OSH = 32 - ANGLE_WIDTH;
  localparam logic [30:0] Kq  = 31'(rme_pkg::gain_q30(CORDIC_STEPS));
  localparam logic [PW-1:0] RoundK = PW'(1) << (rme_pkg::GainShift - 1);

  // input register and gain product
  logic                 v0_q;
  logic signed [EW-1:0] m00_q, m10_q, m01_q, m11_q, m02_q, m12_q;
  logic                 neg20_q, nz20_q;
  logic [PW-1:0]        prod_q;
  logic [EW-1:0]        abs20;

  always_comb begin
    abs20 = m20_i[EW-1] ? (~m20_i + EW'(1)) : m20_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m00_q   <= m00_i;
    m10_q   <= m10_i;
    m01_q   <= m01_i;
    m11_q   <= m11_i;
    m02_q   <= m02_i;
    m12_q   <= m12_i;
    neg20_q <= m20_i[EW-1];
    nz20_q  <= |m20_i;
    prod_q  <= PW'(abs20) * PW'(Kq);
  end

  // yaw setup
  logic signed [DW-1:0] yx [0:S];
  logic signed [DW-1:0] yy [0:S];
  logic        [31:0]   yz [0:S];
  logic signed [DW-1:0] ya0 [0:S];
  logic signed [DW-1:0] yb0 [0:S];
  logic signed [DW-1:0] ya1 [0:S];
  logic signed [DW-1:0] yb1 [0:S];
  logic signed [DW-1:0] yky [0:S];
  logic                 yzero [0:S];
  logic                 yv [0:S];

  logic                 zy_d, flip_d;
  logic signed [DW-1:0] x_d, y_d, a0_d, b0_d, a1_d, b1_d, mag_d;
  logic [PW-1:0]        rnd_d;

  always_comb begin
    zy_d  = (m00_q == '0) && (m10_q == '0);
    x_d   = zy_d ? (DW'(1) <<< rme_pkg::GuardBits)
                 : (DW'(m00_q) <<< rme_pkg::GuardBits);
    y_d   = zy_d ? '0 : (DW'(m10_q) <<< rme_pkg::GuardBits);
    a0_d  = DW'(m01_q) <<< rme_pkg::GuardBits;
    b0_d  = DW'(m11_q) <<< rme_pkg::GuardBits;
    a1_d  = DW'(m02_q) <<< rme_pkg::GuardBits;
    b1_d  = DW'(m12_q) <<< rme_pkg::GuardBits;
    flip_d = x_d[DW-1];
    rnd_d = prod_q + RoundK;
    mag_d = DW'(rnd_d[PW-1:rme_pkg::GainShift]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yv[0] <= 1'b0;
    end else begin
      yv[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yx[0]    <= flip_d ? -x_d : x_d;
    yy[0]    <= flip_d ? -y_d : y_d;
    ya0[0]   <= flip_d ? -a0_d : a0_d;
    yb0[0]   <= flip_d ? -b0_d : b0_d;
    ya1[0]   <= flip_d ? -a1_d : a1_d;
    yb1[0]   <= flip_d ? -b1_d : b1_d;
    yz[0]    <= flip_d ? rme_pkg::HalfTurn : '0;
    yky[0]   <= (neg20_q || !nz20_q) ? mag_d : -mag_d;
    yzero[0] <= zy_d;
  end

  for (genvar i = 0; i < S; i++) begin : g_yaw
    rme_yaw_cell #(.DW(DW), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (yv[i]),
      .x_i     (yx[i]),
      .y_i     (yy[i]),
      .z_i     (yz[i]),
      .a0_i    (ya0[i]),
      .b0_i    (yb0[i]),
      .a1_i    (ya1[i]),
      .b1_i    (yb1[i]),
      .ky_i    (yky[i]),
      .zero_i  (yzero[i]),
      .valid_o (yv[i+1]),
      .x_o     (yx[i+1]),
      .y_o     (yy[i+1]),
      .z_o     (yz[i+1]),
      .a0_o    (ya0[i+1]),
      .b0_o    (yb0[i+1]),
      .a1_o    (ya1[i+1]),
      .b1_o    (yb1[i+1]),
      .ky_o    (yky[i+1]),
      .zero_o  (yzero[i+1])
    );
  end

  // pitch and roll setup
  logic signed [DW-1:0] px [0:S];
  logic signed [DW-1:0] py [0:S];
  logic        [31:0]   pz [0:S];
  logic signed [DW-1:0] rx [0:S];
  logic signed [DW-1:0] ry [0:S];
  logic        [31:0]   rz [0:S];
  logic                 pzero [0:S];
  logic                 rzero [0:S];
  logic        [31:0]   yawz [0:S];
  logic                 pv [0:S];

  logic signed [DW-1:0] r_d, rr_x, rr_y;

  always_comb begin
    r_d  = yzero[S] ? '0 : yx[S];
    rr_x = yb0[S];
    rr_y = -yb1[S];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv[0] <= 1'b0;
    end else begin
      pv[0] <= yv[S];
    end
  end

  always_ff @(posedge clk_i) begin
    px[0]    <= r_d[DW-1] ? -r_d : r_d;
    py[0]    <= r_d[DW-1] ? -yky[S] : yky[S];
    pz[0]    <= r_d[DW-1] ? rme_pkg::HalfTurn : '0;
    rx[0]    <= rr_x[DW-1] ? -rr_x : rr_x;
    ry[0]    <= rr_x[DW-1] ? -rr_y : rr_y;
    rz[0]    <= rr_x[DW-1] ? rme_pkg::HalfTurn : '0;
    pzero[0] <= (r_d == '0) && (yky[S] == '0);
    rzero[0] <= (rr_x == '0) && (rr_y == '0);
    yawz[0]  <= yzero[S] ? '0 : yz[S];
  end

  for (genvar i = 0; i < S; i++) begin : g_pr
    rme_pr_cell #(.DW(DW), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pv[i]),
      .px_i    (px[i]),
      .py_i    (py[i]),
      .pz_i    (pz[i]),
      .rx_i    (rx[i]),
      .ry_i    (ry[i]),
      .rz_i    (rz[i]),
      .pzero_i (pzero[i]),
      .rzero_i (rzero[i]),
      .yaw_i   (yawz[i]),
      .valid_o (pv[i+1]),
      .px_o    (px[i+1]),
      .py_o    (py[i+1]),
      .pz_o    (pz[i+1]),
      .rx_o    (rx[i+1]),
      .ry_o    (ry[i+1]),
      .rz_o    (rz[i+1]),
      .pzero_o (pzero[i+1]),
      .rzero_o (rzero[i+1]),
      .yaw_o   (yawz[i+1])
    );
  end

  // round to output width
  logic [31:0] yaw_r, pitch_r, roll_r;

  if (OSH > 0) begin : g_round
    localparam logic [31:0] Half = 32'(1) << (OSH - 1);
    always_comb begin
      yaw_r   = (yawz[S] + Half) >> OSH;
      pitch_r = ((pzero[S] ? 32'd0 : pz[S]) + Half) >> OSH;
      roll_r  = ((rzero[S] ? 32'd0 : rz[S]) + Half) >> OSH;
    end
  end else begin : g_noround
    always_comb begin
      yaw_r   = yawz[S];
      pitch_r = pzero[S] ? 32'd0 : pz[S];
      roll_r  = rzero[S] ? 32'd0 : rz[S];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= pv[S];
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_angle_o   <= yaw_r[ANGLE_WIDTH-1:0];
    pitch_angle_o <= pitch_r[ANGLE_WIDTH-1:0];
    roll_angle_o  <= roll_r[ANGLE_WIDTH-1:0];
  end

  assign busy_o = 1'b0;
endmodule
`default_nettype wire
